### src/bpa_pkg.sv
package bpa_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int TOP_ORDER  = 10;
    localparam int LISTS      = TOP_ORDER + 1;
    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam int LINK_W     = IDX_W + 1;
    localparam int ORD_W      = 4;
    localparam int FRAME_W    = 52;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = 11;

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(PAGE_COUNT);
    localparam logic [ORD_W-1:0]  ORD_NONE  = 4'd15;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_ADD   = 2'd2,
        FN_BAD   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_TOOBIG  = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic              owned;
        logic              is_free;
        logic              alloc;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_page;

    localparam int PAGE_W = $bits(t_page);

    localparam t_page PAGE_RST = '{owned: 1'b0, is_free: 1'b0, alloc: 1'b0,
                                   order: ORD_NONE, nxt: NIL, prv: NIL};

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_A_UNP, S_A_RDN, S_A_WRN, S_A_SPL, S_A_WRQ,
        S_RDH, S_WRH,
        S_F_CHK, S_D_CHK,
        S_M_BUD, S_M_BIX, S_M_BCK, S_M_RDQ, S_M_WRQ, S_M_RDN, S_M_WRN,
        S_P_RDP, S_P_WRP,
        S_FIN
    } t_state;

endpackage

### src/bpa_req_if.sv
interface bpa_req_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [ORD_W-1:0]   block_order;
    logic [FRAME_W-1:0] frame;

    modport source (output valid, func, block_order, frame, input ready);
    modport sink   (input valid, func, block_order, frame, output ready);
endinterface

### src/bpa_rsp_if.sv
interface bpa_rsp_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] result_frame;
    logic [CNT_W-1:0]   pages_free;

    modport source (output valid, status, result_frame, pages_free, input ready);
    modport sink   (input valid, status, result_frame, pages_free, output ready);
endinterface

### src/bpa_ram.sv
module bpa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/buddy_page_allocator_top.sv
// Binary buddy allocator over a pool of 1024 page frames starting at first_frame.
// Requests are allocate, free block and add page; each gives exactly one
// response. All per-page state sits in one synchronous RAM, walked by a
// read-modify-write sequencer, and one request is worked on at a time. After
// reset the block sweeps the RAM, clearing every page entry, before taking its
// first request. An allocate pops a block and splits it down to the requested
// order; a free or add merges with free buddies up to the top order and then
// inserts the result into its free list. The response is held in an output
// register, so a new request is taken while it waits.
module buddy_page_allocator_top import bpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FRAME_W-1:0] i_cfg_wdata,
    bpa_req_if.sink            i_req,
    bpa_rsp_if.source          o_rsp
);
    t_state r_state, n_state;

    logic [FRAME_W-1:0] r_first, n_first;
    logic [LINK_W-1:0]  r_head [LISTS];
    logic [LINK_W-1:0]  n_head [LISTS];
    logic [CNT_W-1:0]   r_total, n_total;
    logic [IDX_W:0]     r_clr, n_clr;
    logic [1:0]         r_func, n_func;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [ORD_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_p, n_p;
    logic [IDX_W-1:0]   r_q, n_q;
    logic [IDX_W-1:0]   r_b, n_b;
    logic [LINK_W-1:0]  r_h, n_h;
    logic [LINK_W-1:0]  r_n, n_n;
    logic [LINK_W-1:0]  r_pq, n_pq;
    logic [FRAME_W:0]   r_bf, n_bf;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [FRAME_W-1:0] r_rframe, n_rframe;
    logic               r_ovalid, n_ovalid;
    logic [STAT_W-1:0]  r_ostatus, n_ostatus;
    logic [FRAME_W-1:0] r_oframe, n_oframe;
    logic [CNT_W-1:0]   r_ofree, n_ofree;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    t_page              mem_wdata, mem_rdata;

    logic               found;
    logic [ORD_W-1:0]   kf;
    logic [FRAME_W-1:0] req_off;
    logic               req_in;
    logic [FRAME_W:0]   first_x, bix_off;
    logic               bix_ok;
    logic [ORD_W-1:0]   ks;
    t_page              wr;

    bpa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(PAGE_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostatus;
    assign o_rsp.result_frame = r_oframe;
    assign o_rsp.pages_free   = r_ofree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_first  <= '0;
            r_total  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < LISTS; i++) begin
                r_head[i] <= NIL;
            end
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_total  <= n_total;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_head   <= n_head;
        end
        r_func    <= n_func;
        r_ord     <= n_ord;
        r_k       <= n_k;
        r_p       <= n_p;
        r_q       <= n_q;
        r_b       <= n_b;
        r_h       <= n_h;
        r_n       <= n_n;
        r_pq      <= n_pq;
        r_bf      <= n_bf;
        r_status  <= n_status;
        r_rframe  <= n_rframe;
        r_ostatus <= n_ostatus;
        r_oframe  <= n_oframe;
        r_ofree   <= n_ofree;
    end

    // lowest non-empty list at or above the requested order
    always_comb begin
        found = 1'b0;
        kf    = '0;
        for (int j = 0; j < LISTS; j++) begin
            if (!found && ORD_W'(j) >= i_req.block_order && r_head[j] != NIL) begin
                found = 1'b1;
                kf    = ORD_W'(j);
            end
        end
    end

    assign req_off = i_req.frame - r_first;
    assign req_in  = (i_req.frame >= r_first) && (req_off < FRAME_W'(PAGE_COUNT));
    assign first_x = {1'b0, r_first};
    assign bix_off = r_bf - first_x;
    assign bix_ok  = (r_bf >= first_x) && (bix_off < (FRAME_W+1)'(PAGE_COUNT));
    assign ks      = r_k - 4'd1;

    always_comb begin
        n_state   = r_state;
        n_first   = i_cfg_we ? i_cfg_wdata : r_first;
        n_head    = r_head;
        n_total   = r_total;
        n_clr     = r_clr;
        n_func    = r_func;
        n_ord     = r_ord;
        n_k       = r_k;
        n_p       = r_p;
        n_q       = r_q;
        n_b       = r_b;
        n_h       = r_h;
        n_n       = r_n;
        n_pq      = r_pq;
        n_bf      = r_bf;
        n_status  = r_status;
        n_rframe  = r_rframe;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_ostatus = r_ostatus;
        n_oframe  = r_oframe;
        n_ofree   = r_ofree;
        mem_we    = 1'b0;
        mem_waddr = r_p;
        mem_raddr = r_p;
        wr        = mem_rdata;
        mem_wdata = wr;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr[IDX_W-1:0];
                mem_wdata = PAGE_RST;
                n_clr     = r_clr + 1'b1;
                if (r_clr == (IDX_W+1)'(PAGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func   = i_req.func;
                    n_ord    = i_req.block_order;
                    n_status = ST_DONE;
                    n_rframe = '0;
                    n_state  = S_FIN;
                    case (i_req.func)
                        FN_ALLOC: begin
                            if (i_req.block_order > ORD_W'(TOP_ORDER)) begin
                                n_status = ST_TOOBIG;
                            end else if (!found) begin
                                n_status = ST_NOFREE;
                            end else begin
                                n_k       = kf;
                                n_p       = r_head[kf][IDX_W-1:0];
                                mem_raddr = r_head[kf][IDX_W-1:0];
                                n_state   = S_A_UNP;
                            end
                        end
                        FN_FREE: begin
                            if (i_req.block_order > ORD_W'(TOP_ORDER)) begin
                                n_status = ST_TOOBIG;
                            end else if (!req_in) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_p       = req_off[IDX_W-1:0];
                                mem_raddr = req_off[IDX_W-1:0];
                                n_state   = S_F_CHK;
                            end
                        end
                        FN_ADD: begin
                            if (!req_in) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_p       = req_off[IDX_W-1:0];
                                mem_raddr = req_off[IDX_W-1:0];
                                n_state   = S_D_CHK;
                            end
                        end
                        default: n_status = ST_INVALID;
                    endcase
                end
            end
            S_A_UNP: begin
                // pop the head; it becomes the allocated block right away
                n_head[r_k] = mem_rdata.nxt;
                wr.is_free  = 1'b0;
                wr.alloc    = 1'b1;
                wr.order    = r_ord;
                wr.nxt      = NIL;
                wr.prv      = NIL;
                mem_we      = 1'b1;
                mem_wdata   = wr;
                n_total     = r_total - (CNT_W'(1) << r_ord);
                n_rframe    = r_first + FRAME_W'(r_p);
                n_n         = mem_rdata.nxt;
                n_state     = (mem_rdata.nxt != NIL) ? S_A_RDN : S_A_SPL;
            end
            S_A_RDN: begin
                mem_raddr = r_n[IDX_W-1:0];
                n_state   = S_A_WRN;
            end
            S_A_WRN: begin
                wr.prv    = NIL;
                mem_we    = 1'b1;
                mem_waddr = r_n[IDX_W-1:0];
                mem_wdata = wr;
                n_state   = S_A_SPL;
            end
            S_A_SPL: begin
                if (r_k > r_ord) begin
                    n_k       = ks;
                    n_q       = r_p + (IDX_W'(1) << ks);
                    mem_raddr = r_p + (IDX_W'(1) << ks);
                    n_state   = S_A_WRQ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_A_WRQ: begin
                wr.nxt      = r_head[r_k];
                wr.prv      = NIL;
                wr.is_free  = 1'b1;
                wr.order    = r_k;
                mem_we      = 1'b1;
                mem_waddr   = r_q;
                mem_wdata   = wr;
                n_head[r_k] = {1'b0, r_q};
                n_h         = r_head[r_k];
                n_state     = (r_head[r_k] != NIL) ? S_RDH : S_A_SPL;
            end
            S_RDH: begin
                mem_raddr = r_h[IDX_W-1:0];
                n_state   = S_WRH;
            end
            S_WRH: begin
                wr.prv    = {1'b0, r_q};
                mem_we    = 1'b1;
                mem_waddr = r_h[IDX_W-1:0];
                mem_wdata = wr;
                n_state   = (r_func == FN_ALLOC) ? S_A_SPL : S_FIN;
            end
            S_F_CHK: begin
                if (!mem_rdata.alloc || mem_rdata.order != r_ord) begin
                    n_status = ST_INVALID;
                    n_state  = S_FIN;
                end else begin
                    wr.alloc  = 1'b0;
                    wr.order  = ORD_NONE;
                    mem_we    = 1'b1;
                    mem_wdata = wr;
                    n_total   = r_total + (CNT_W'(1) << r_ord);
                    n_k       = r_ord;
                    n_state   = S_M_BUD;
                end
            end
            S_D_CHK: begin
                if (mem_rdata.owned) begin
                    n_status = ST_INVALID;
                    n_state  = S_FIN;
                end else begin
                    wr.owned  = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = wr;
                    n_total   = r_total + 1'b1;
                    n_k       = '0;
                    n_state   = S_M_BUD;
                end
            end
            S_M_BUD: begin
                if (r_k < ORD_W'(TOP_ORDER)) begin
                    n_bf    = (first_x + (FRAME_W+1)'(r_p))
                              ^ ((FRAME_W+1)'(1) << r_k);
                    n_state = S_M_BIX;
                end else begin
                    n_state = S_P_RDP;
                end
            end
            S_M_BIX: begin
                if (bix_ok) begin
                    n_b       = bix_off[IDX_W-1:0];
                    mem_raddr = bix_off[IDX_W-1:0];
                    n_state   = S_M_BCK;
                end else begin
                    n_state = S_P_RDP;
                end
            end
            S_M_BCK: begin
                if (mem_rdata.is_free && mem_rdata.order == r_k) begin
                    // unlink the buddy, then fix its neighbors
                    wr.is_free = 1'b0;
                    wr.order   = ORD_NONE;
                    wr.nxt     = NIL;
                    wr.prv     = NIL;
                    mem_we     = 1'b1;
                    mem_waddr  = r_b;
                    mem_wdata  = wr;
                    n_n        = mem_rdata.nxt;
                    n_pq       = mem_rdata.prv;
                    if (mem_rdata.prv == NIL) begin
                        n_head[r_k] = mem_rdata.nxt;
                    end
                    if (r_b < r_p) begin
                        n_p = r_b;
                    end
                    n_k = r_k + 1'b1;
                    if (mem_rdata.prv != NIL) begin
                        n_state = S_M_RDQ;
                    end else if (mem_rdata.nxt != NIL) begin
                        n_state = S_M_RDN;
                    end else begin
                        n_state = S_M_BUD;
                    end
                end else begin
                    n_state = S_P_RDP;
                end
            end
            S_M_RDQ: begin
                mem_raddr = r_pq[IDX_W-1:0];
                n_state   = S_M_WRQ;
            end
            S_M_WRQ: begin
                wr.nxt    = r_n;
                mem_we    = 1'b1;
                mem_waddr = r_pq[IDX_W-1:0];
                mem_wdata = wr;
                n_state   = (r_n != NIL) ? S_M_RDN : S_M_BUD;
            end
            S_M_RDN: begin
                mem_raddr = r_n[IDX_W-1:0];
                n_state   = S_M_WRN;
            end
            S_M_WRN: begin
                wr.prv    = r_pq;
                mem_we    = 1'b1;
                mem_waddr = r_n[IDX_W-1:0];
                mem_wdata = wr;
                n_state   = S_M_BUD;
            end
            S_P_RDP: begin
                mem_raddr = r_p;
                n_state   = S_P_WRP;
            end
            S_P_WRP: begin
                wr.nxt      = r_head[r_k];
                wr.prv      = NIL;
                wr.is_free  = 1'b1;
                wr.order    = r_k;
                mem_we      = 1'b1;
                mem_wdata   = wr;
                n_head[r_k] = {1'b0, r_p};
                n_q         = r_p;
                n_h         = r_head[r_k];
                n_state     = (r_head[r_k] != NIL) ? S_RDH : S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oframe  = r_rframe;
                    n_ofree   = r_total;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
